FILE: rtl/lbpc_pkg.sv
// Shared types, constants and register map of the level-bar pixel color unit.
// No dependencies; every other file of the block imports this package.
package lbpc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_LEDS   = 256;

  localparam int PIX_W  = 8;
  localparam int VOL_W  = 11;
  localparam int HUE_W  = 8;
  localparam int CH_W   = 8;
  localparam int LEN_W  = 9;
  localparam int NUM_W  = 19;
  localparam int QUO_W  = 8;
  localparam int FULL_SCALE = 1024;

  // pipeline geometry
  localparam int GEOM_STAGES = 2;
  localparam int DIV_BPS     = 2;
  localparam int DIV_STAGES  = QUO_W / DIV_BPS;
  localparam int HSV_STAGES  = DIV_STAGES + 1;
  localparam int MIX_STAGES  = 2;
  localparam int PIPE_STAGES = GEOM_STAGES + HSV_STAGES + 1;

  // reciprocal multipliers: 24/17 scale, /60 sector, /60 fraction
  localparam int HUE_SCALE_SHIFT = 20;
  localparam int HUE_SCALE_MUL   = 24 * ((1 << HUE_SCALE_SHIFT) / 17 + 1);
  localparam int SECTOR_SPAN     = 60;
  localparam int SECTOR_SHIFT    = 16;
  localparam int SECTOR_RECIP    = (1 << SECTOR_SHIFT) / SECTOR_SPAN + 1;
  localparam int FRAC_SHIFT      = 20;
  localparam int FRAC_RECIP      = (1 << FRAC_SHIFT) / SECTOR_SPAN + 1;
  localparam int SECTOR_COUNT    = 6;
  localparam int DIM_LIMIT       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANIM_MODE,
    REG_STRIP_LENGTH,
    REG_HUE_STEP,
    REG_HUE_OFFSET,
    REG_MAIN_HUE,
    REG_BACKGROUND_HUE,
    REG_MAIN_SAT_BRIGHT,
    REG_BACK_SAT_BRIGHT
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_RAINBOW,
    MODE_STATIC,
    MODE_FLAT
  } anim_mode_t;

  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP,
    SEC_GREEN_RED_DOWN,
    SEC_GREEN_BLUE_UP,
    SEC_BLUE_GREEN_DOWN,
    SEC_BLUE_RED_UP,
    SEC_RED_BLUE_DOWN
  } sector_t;

  typedef struct packed {
    logic [1:0]        anim_mode;
    logic [LEN_W-1:0]  strip_length;
    logic [HUE_W-1:0]  hue_step_per_pixel;
    logic [HUE_W-1:0]  hue_offset;
    logic [HUE_W-1:0]  main_hue;
    logic [HUE_W-1:0]  background_hue;
    logic [15:0]       main_sat_bright;
    logic [15:0]       back_sat_bright;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    anim_mode:          2'd0,
    strip_length:       9'd256,
    hue_step_per_pixel: 8'd20,
    hue_offset:         8'd0,
    main_hue:           8'd0,
    background_hue:     8'd0,
    main_sat_bright:    16'hFFFF,
    back_sat_bright:    16'hFFFF
  };

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             blend;
    logic [LEN_W-1:0] len;
    logic [NUM_W-1:0] num;
  } div_in_t;

  typedef struct packed {
    logic             blend;
    logic [QUO_W-1:0] w;
  } div_out_t;

endpackage

FILE: rtl/lbpc_channels.sv
// Valid/ready channel interfaces of the level-bar pixel color unit.
// Depends on lbpc_pkg for field widths.
interface lbpc_pixel_if;
  import lbpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_index;
  logic [VOL_W-1:0] volume_level;
  logic [HUE_W-1:0] hue_base;

  modport source(output valid, pixel_index, volume_level, hue_base, input ready);
  modport sink(input valid, pixel_index, volume_level, hue_base, output ready);
endinterface

interface lbpc_color_if;
  import lbpc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

FILE: rtl/lbpc_geom.sv
// Front stages: level threshold compare, blend decision, divide operands, hue and
// HSV operand selection. Depends on lbpc_pkg.
module lbpc_geom (
  input  logic                              clk,
  input  logic [lbpc_pkg::GEOM_STAGES-1:0]  en,
  input  lbpc_pkg::cfg_t                    cfg,
  input  logic [lbpc_pkg::PIX_W-1:0]        pixel_index,
  input  logic [lbpc_pkg::VOL_W-1:0]        volume_level,
  input  logic [lbpc_pkg::HUE_W-1:0]        hue_base,
  output lbpc_pkg::div_in_t                 div_req,
  output lbpc_pkg::hsv_in_t                 hsv_a,
  output lbpc_pkg::hsv_in_t                 hsv_b
);
  import lbpc_pkg::*;

  // stage 1
  logic [PIX_W-1:0]   s1_pix;
  logic [LEN_W-1:0]   s1_len;
  logic signed [21:0] s1_lprod;
  logic [HUE_W-1:0]   s1_hue_rb;

  logic [LEN_W-1:0]   len_sat;
  logic signed [11:0] thr;
  logic signed [21:0] lprod;
  logic [15:0]        rb_sum;

  always_comb begin
    len_sat = (cfg.strip_length > LEN_W'(MAX_LEDS)) ? LEN_W'(MAX_LEDS) : cfg.strip_length;
    thr     = $signed(12'(FULL_SCALE)) - $signed({1'b0, volume_level});
    lprod   = thr * $signed({1'b0, len_sat});
    rb_sum  = 16'(pixel_index) * 16'(cfg.hue_step_per_pixel)
            + 16'(hue_base) + 16'(cfg.hue_offset);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_pix    <= pixel_index;
      s1_len    <= len_sat;
      s1_lprod  <= lprod;
      s1_hue_rb <= rb_sum[HUE_W-1:0];
    end
  end

  // stage 2
  logic signed [22:0] d;
  logic [19:0]        ad;
  logic [24:0]        ad20;
  logic [18:0]        span;
  logic signed [27:0] d20;
  logic signed [27:0] numw;
  logic               above;
  logic               blend;
  logic [HUE_W-1:0]   hue;
  logic [CH_W-1:0]    s_own;
  logic [CH_W-1:0]    v_own;
  hsv_in_t            a_next;

  always_comb begin
    d     = $signed({5'b0, s1_pix, 10'b0}) - {s1_lprod[21], s1_lprod};
    above = !d[22] && (d != '0);
    ad    = d[22] ? 20'(-d) : 20'(d);
    ad20  = {1'b0, ad, 4'b0} + {3'b0, ad, 2'b0};
    span  = {s1_len, 10'b0};
    blend = ad20 < {6'b0, span};
    d20   = $signed({d[22], d, 4'b0}) + $signed({{3{d[22]}}, d, 2'b0});
    numw  = $signed({9'b0, span}) - d20;

    unique case (anim_mode_t'(cfg.anim_mode))
      MODE_RAINBOW: hue = s1_hue_rb;
      MODE_STATIC:  hue = above ? cfg.main_hue : cfg.background_hue;
      default:      hue = '0;
    endcase

    s_own = above ? cfg.main_sat_bright[15:8] : cfg.back_sat_bright[15:8];
    v_own = above ? cfg.main_sat_bright[7:0]  : cfg.back_sat_bright[7:0];
    if (blend) begin
      a_next = '{hue: hue, sat: cfg.main_sat_bright[15:8], val: cfg.main_sat_bright[7:0]};
    end else if (v_own < CH_W'(DIM_LIMIT)) begin
      a_next = '{hue: '0, sat: '0, val: v_own};
    end else begin
      a_next = '{hue: hue, sat: s_own, val: v_own};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      div_req.blend <= blend;
      div_req.len   <= s1_len;
      div_req.num   <= numw[NUM_W-1:0];
      hsv_a         <= a_next;
      hsv_b         <= '{hue: hue, sat: cfg.back_sat_bright[15:8],
                         val: cfg.back_sat_bright[7:0]};
    end
  end

endmodule

FILE: rtl/lbpc_div.sv
// Pipelined restoring divider for the blend weight, num / (8 * len), 8-bit quotient,
// two quotient bits per stage. Depends on lbpc_pkg.
module lbpc_div (
  input  logic                             clk,
  input  logic [lbpc_pkg::DIV_STAGES-1:0]  en,
  input  lbpc_pkg::div_in_t                req,
  output lbpc_pkg::div_out_t               res
);
  import lbpc_pkg::*;

  localparam int DIV_W = NUM_W + 1;

  logic [NUM_W-1:0] rem      [DIV_STAGES];
  logic [QUO_W-1:0] quo      [DIV_STAGES];
  logic [LEN_W-1:0] len      [DIV_STAGES];
  logic             blend    [DIV_STAGES];
  logic [NUM_W-1:0] rem_next [DIV_STAGES];
  logic [QUO_W-1:0] quo_next [DIV_STAGES];
  logic [LEN_W-1:0] len_src  [DIV_STAGES];
  logic             blend_src[DIV_STAGES];

  always_comb begin
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] sh;
    logic [QUO_W-1:0] q;
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (j == 0) begin
        r            = {1'b0, req.num};
        q            = '0;
        len_src[j]   = req.len;
        blend_src[j] = req.blend;
      end else begin
        r            = {1'b0, rem[j-1]};
        q            = quo[j-1];
        len_src[j]   = len[j-1];
        blend_src[j] = blend[j-1];
      end
      for (int k = 0; k < DIV_BPS; k++) begin
        sh = {{(DIV_W-LEN_W){1'b0}}, len_src[j]} << (3 + QUO_W - 1 - j * DIV_BPS - k);
        q  = {q[QUO_W-2:0], (r >= sh)};
        if (r >= sh) begin
          r = r - sh;
        end
      end
      rem_next[j] = r[NUM_W-1:0];
      quo_next[j] = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[j]) begin
        rem[j]   <= rem_next[j];
        quo[j]   <= quo_next[j];
        len[j]   <= len_src[j];
        blend[j] <= blend_src[j];
      end
    end
  end

  assign res.blend = blend[DIV_STAGES-1];
  assign res.w     = quo[DIV_STAGES-1];

endmodule

FILE: rtl/lbpc_hsv.sv
// Five-stage integer HSV to RGB converter: 0..360 hue scale, six 60-unit sectors.
// Depends on lbpc_pkg.
module lbpc_hsv (
  input  logic                             clk,
  input  logic [lbpc_pkg::HSV_STAGES-1:0]  en,
  input  lbpc_pkg::hsv_in_t                hsv,
  output lbpc_pkg::rgb_t                   rgb
);
  import lbpc_pkg::*;

  logic [8:0]      s0_h360;
  logic [15:0]     s0_vs;
  logic [CH_W-1:0] s0_v;

  sector_t         s1_zone;
  logic [5:0]      s1_frac;
  logic [CH_W-1:0] s1_c;
  logic [CH_W-1:0] s1_v;

  sector_t         s2_zone;
  logic [13:0]     s2_prod;
  logic [CH_W-1:0] s2_c;
  logic [CH_W-1:0] s2_v;

  sector_t         s3_zone;
  logic [CH_W-1:0] s3_a;
  logic [CH_W-1:0] s3_lo;
  logic [CH_W-1:0] s3_v;

  logic [28:0]     hprod;
  logic [19:0]     qprod;
  logic [2:0]      q;
  logic [8:0]      frac9;
  logic [27:0]     aprod;
  logic [CH_W-1:0] up;
  logic [CH_W-1:0] dn;
  rgb_t            rgb_next;

  always_comb begin
    hprod = 29'(hsv.hue) * 29'(HUE_SCALE_MUL);
    qprod = 20'(s0_h360) * 20'(SECTOR_RECIP);
    q     = qprod[SECTOR_SHIFT +: 3];
    frac9 = s0_h360 - 9'(q * 9'(SECTOR_SPAN));
    aprod = 28'(s2_prod) * 28'(FRAC_RECIP);
    up    = s3_lo + s3_a;
    dn    = s3_v - s3_a;
    unique case (s3_zone)
      SEC_RED_GREEN_UP:    rgb_next = '{red: s3_v,  green: up,    blue: s3_lo};
      SEC_GREEN_RED_DOWN:  rgb_next = '{red: dn,    green: s3_v,  blue: s3_lo};
      SEC_GREEN_BLUE_UP:   rgb_next = '{red: s3_lo, green: s3_v,  blue: up};
      SEC_BLUE_GREEN_DOWN: rgb_next = '{red: s3_lo, green: dn,    blue: s3_v};
      SEC_BLUE_RED_UP:     rgb_next = '{red: up,    green: s3_lo, blue: s3_v};
      default:             rgb_next = '{red: s3_v,  green: s3_lo, blue: dn};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_h360 <= hprod[HUE_SCALE_SHIFT +: 9];
      s0_vs   <= 16'(hsv.val) * 16'(hsv.sat);
      s0_v    <= hsv.val;
    end
    if (en[1]) begin
      // full circle wraps back to the first sector
      s1_zone <= (q == 3'(SECTOR_COUNT)) ? SEC_RED_GREEN_UP : sector_t'(q);
      s1_frac <= frac9[5:0];
      s1_c    <= s0_vs[15:8];
      s1_v    <= s0_v;
    end
    if (en[2]) begin
      s2_zone <= s1_zone;
      s2_prod <= 14'(s1_c) * 14'(s1_frac);
      s2_c    <= s1_c;
      s2_v    <= s1_v;
    end
    if (en[3]) begin
      s3_zone <= s2_zone;
      s3_a    <= aprod[FRAC_SHIFT +: CH_W];
      s3_lo   <= s2_v - s2_c;
      s3_v    <= s2_v;
    end
    if (en[4]) begin
      rgb <= rgb_next;
    end
  end

endmodule

FILE: rtl/lbpc_mix.sv
// Output stages: aligns the blend weight with the two colors and mixes them,
// or passes the pixel's own color. Depends on lbpc_pkg.
module lbpc_mix (
  input  logic                             clk,
  input  logic [lbpc_pkg::MIX_STAGES-1:0]  en,
  input  lbpc_pkg::div_out_t               weight,
  input  lbpc_pkg::rgb_t                   color_a,
  input  lbpc_pkg::rgb_t                   color_b,
  output lbpc_pkg::rgb_t                   rgb
);
  import lbpc_pkg::*;

  logic             blend;
  logic [QUO_W-1:0] w;
  rgb_t             mixed;

  // floor(((256-w)*m + w*b) / 256) == m + floor(w*(b-m) / 256)
  function automatic logic [CH_W-1:0] mix_ch(input logic [CH_W-1:0] m,
                                             input logic [CH_W-1:0] b,
                                             input logic [QUO_W-1:0] wt);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [9:0]  sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, m});
    prod = $signed({1'b0, wt}) * diff;
    sum  = $signed({2'b0, m}) + prod[17:8];
    return sum[CH_W-1:0];
  endfunction

  always_comb begin
    mixed.red   = mix_ch(color_a.red,   color_b.red,   w);
    mixed.green = mix_ch(color_a.green, color_b.green, w);
    mixed.blue  = mix_ch(color_a.blue,  color_b.blue,  w);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      blend <= weight.blend;
      w     <= weight.w;
    end
    if (en[1]) begin
      rgb <= blend ? mixed : color_a;
    end
  end

endmodule

FILE: rtl/level_bar_pixel_color_unit.sv
// Level-bar pixel color unit: LED index + volume level + base hue -> 8-bit RGB.
// Throughput: one pixel per cycle while the output accepts beats; each of the 8
// stages advances when it is empty or the stage after it advances, so bubbles
// fill while the output is stalled.
// Reset (synchronous): clears all stage valid bits and loads register defaults.
module level_bar_pixel_color_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbpc_pkg::CFG_DATA_W-1:0] cfg_data,
  lbpc_pixel_if.sink                      pixel,
  lbpc_color_if.source                    color
);
  import lbpc_pkg::*;

  cfg_t                   cfg;
  logic [PIPE_STAGES-1:0] valid;
  logic [PIPE_STAGES-1:0] en;
  div_in_t                div_req;
  div_out_t               div_res;
  hsv_in_t                hsv_a;
  hsv_in_t                hsv_b;
  rgb_t                   rgb_a;
  rgb_t                   rgb_b;
  rgb_t                   rgb_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        REG_ANIM_MODE:       cfg.anim_mode          <= cfg_data[1:0];
        REG_STRIP_LENGTH:    cfg.strip_length       <= cfg_data[LEN_W-1:0];
        REG_HUE_STEP:        cfg.hue_step_per_pixel <= cfg_data[HUE_W-1:0];
        REG_HUE_OFFSET:      cfg.hue_offset         <= cfg_data[HUE_W-1:0];
        REG_MAIN_HUE:        cfg.main_hue           <= cfg_data[HUE_W-1:0];
        REG_BACKGROUND_HUE:  cfg.background_hue     <= cfg_data[HUE_W-1:0];
        REG_MAIN_SAT_BRIGHT: cfg.main_sat_bright    <= cfg_data;
        REG_BACK_SAT_BRIGHT: cfg.back_sat_bright    <= cfg_data;
      endcase
    end
  end

  always_comb begin
    en[PIPE_STAGES-1] = !valid[PIPE_STAGES-1] || color.ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= pixel.valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign pixel.ready = en[0] && !rst;
  assign color.valid = valid[PIPE_STAGES-1];
  assign color.red   = rgb_out.red;
  assign color.green = rgb_out.green;
  assign color.blue  = rgb_out.blue;

  lbpc_geom u_geom (
    .clk          (clk),
    .en           (en[0 +: GEOM_STAGES]),
    .cfg          (cfg),
    .pixel_index  (pixel.pixel_index),
    .volume_level (pixel.volume_level),
    .hue_base     (pixel.hue_base),
    .div_req      (div_req),
    .hsv_a        (hsv_a),
    .hsv_b        (hsv_b)
  );

  lbpc_div u_div (
    .clk (clk),
    .en  (en[GEOM_STAGES +: DIV_STAGES]),
    .req (div_req),
    .res (div_res)
  );

  lbpc_hsv u_hsv_a (
    .clk (clk),
    .en  (en[GEOM_STAGES +: HSV_STAGES]),
    .hsv (hsv_a),
    .rgb (rgb_a)
  );

  lbpc_hsv u_hsv_b (
    .clk (clk),
    .en  (en[GEOM_STAGES +: HSV_STAGES]),
    .hsv (hsv_b),
    .rgb (rgb_b)
  );

  lbpc_mix u_mix (
    .clk     (clk),
    .en      (en[GEOM_STAGES + DIV_STAGES +: MIX_STAGES]),
    .weight  (div_res),
    .color_a (rgb_a),
    .color_b (rgb_b),
    .rgb     (rgb_out)
  );

endmodule

FILE: rtl/lbpc_checker.sv
// Port-level checker for level_bar_pixel_color_unit, attached by the bind below.
// Depends on lbpc_pkg for the pipeline depth and channel widths.
module lbpc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pixel_valid,
  input logic                      pixel_ready,
  input logic                      color_valid,
  input logic                      color_ready,
  input logic [lbpc_pkg::CH_W-1:0] red,
  input logic [lbpc_pkg::CH_W-1:0] green,
  input logic [lbpc_pkg::CH_W-1:0] blue
);
  import lbpc_pkg::*;

  localparam int CNT_W = $clog2(PIPE_STAGES + 1);

  logic [CNT_W-1:0] outstanding;
  logic             in_beat;
  logic             out_beat;

  assign in_beat  = pixel_valid && pixel_ready;
  assign out_beat = color_valid && color_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + CNT_W'(in_beat) - CNT_W'(out_beat);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !color_valid)
    else $error("color beat valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_ready |=> color_valid && $stable({red, green, blue}))
    else $error("stalled color beat changed or dropped");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    color_ready |-> pixel_ready)
    else $error("input stalled while output is draining");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_W'(PIPE_STAGES))
    else $error("more pixels in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    color_valid |-> outstanding != '0)
    else $error("color beat without an accepted pixel");

endmodule

bind level_bar_pixel_color_unit lbpc_checker u_lbpc_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel.valid),
  .pixel_ready (pixel.ready),
  .color_valid (color.valid),
  .color_ready (color.ready),
  .red         (color.red),
  .green       (color.green),
  .blue        (color.blue)
);
